// ----- design/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle shape collision test package
// Widths, the pair-kind codes and the bundles that pass between the stages.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int RSUM_W    = RAD_W + 1;
  localparam int PROD_W    = DIFF_W + TRIG_W;
  localparam int ROT_W     = PROD_W + 1;
  localparam int SCALED_W  = RAD_W + TRIG_FRAC;
  localparam int SPLIT_W   = ROT_W / 2;
  localparam int PART_W    = 2 * SPLIT_W;
  localparam int SQ_W      = 2 * ROT_W;
  localparam int RSQ_W     = 2 * RAD_W;
  localparam int CC_SQ_W   = 2 * DIFF_W;
  localparam int CC_MAG_W  = 2 * COORD_W + 1;

  typedef enum logic [1:0] {
    FUNC_CIRCLE_CIRCLE = 2'd0,
    FUNC_CIRCLE_RECT   = 2'd1,
    FUNC_RECT_RECT     = 2'd2
  } cst_func_t;

  typedef struct packed {
    logic      valid;
    cst_func_t func;
  } cst_ctl_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic        [RSUM_W-1:0] rsum;
    logic        [RAD_W-1:0]  radius;
    logic        [RAD_W-1:0]  half_width;
    logic        [RAD_W-1:0]  half_height;
    logic signed [TRIG_W-1:0] cos_a;
    logic signed [TRIG_W-1:0] sin_a;
  } cst_geom_t;

  typedef struct packed {
    logic [RAD_W-1:0] half_width;
    logic [RAD_W-1:0] half_height;
    logic [RAD_W-1:0] radius;
  } cst_lim_t;

endpackage

// ----- design/cst_front.sv -----
// ----------------------------------------------------------------------------
// Front stage
// Forms the centre differences and the radius sum and registers the operands.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                                   clk,
  input  logic signed [cst_pkg::COORD_W-1:0]     circle_x,
  input  logic signed [cst_pkg::COORD_W-1:0]     circle_y,
  input  logic        [cst_pkg::RAD_W-1:0]       circle_radius,
  input  logic signed [cst_pkg::COORD_W-1:0]     other_x,
  input  logic signed [cst_pkg::COORD_W-1:0]     other_y,
  input  logic        [cst_pkg::RAD_W-1:0]       other_radius,
  input  logic        [cst_pkg::RAD_W-1:0]       half_width,
  input  logic        [cst_pkg::RAD_W-1:0]       half_height,
  input  logic signed [cst_pkg::TRIG_W-1:0]      cos_angle,
  input  logic signed [cst_pkg::TRIG_W-1:0]      sin_angle,
  output cst_pkg::cst_geom_t                     geom
);

  cst_pkg::cst_geom_t geom_r;
  cst_pkg::cst_geom_t geom_nxt;

  always_comb begin
    geom_nxt.dx          = {circle_x[cst_pkg::COORD_W-1], circle_x}
                         - {other_x[cst_pkg::COORD_W-1], other_x};
    geom_nxt.dy          = {circle_y[cst_pkg::COORD_W-1], circle_y}
                         - {other_y[cst_pkg::COORD_W-1], other_y};
    geom_nxt.rsum        = {1'b0, circle_radius} + {1'b0, other_radius};
    geom_nxt.radius      = circle_radius;
    geom_nxt.half_width  = half_width;
    geom_nxt.half_height = half_height;
    geom_nxt.cos_a       = cos_angle;
    geom_nxt.sin_a       = sin_angle;
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

// ----- design/cst_circ.sv -----
// ----------------------------------------------------------------------------
// Circle pair test
// Squares the centre differences and the radius sum, then compares the sums.
// ----------------------------------------------------------------------------
module cst_circ (
  input  logic               clk,
  input  cst_pkg::cst_geom_t geom,
  output logic               cc_hit
);

  logic signed [cst_pkg::CC_SQ_W-1:0]   sqx_r;
  logic signed [cst_pkg::CC_SQ_W-1:0]   sqy_r;
  logic        [2*cst_pkg::RSUM_W-1:0]  rsq_r;
  logic signed [cst_pkg::CC_SQ_W-1:0]   sqx_nxt;
  logic signed [cst_pkg::CC_SQ_W-1:0]   sqy_nxt;
  logic        [2*cst_pkg::RSUM_W-1:0]  rsq_nxt;
  logic        [cst_pkg::CC_MAG_W:0]    d2;
  logic                                 hit_r;
  logic                                 hit_nxt;

  always_comb begin
    sqx_nxt = $signed(geom.dx) * $signed(geom.dx);
    sqy_nxt = $signed(geom.dy) * $signed(geom.dy);
    rsq_nxt = geom.rsum * geom.rsum;
  end

  always_comb begin
    d2      = {1'b0, sqx_r[cst_pkg::CC_MAG_W-1:0]} + {1'b0, sqy_r[cst_pkg::CC_MAG_W-1:0]};
    hit_nxt = d2 <= (cst_pkg::CC_MAG_W+1)'(rsq_r);
  end

  always_ff @(posedge clk) begin
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    rsq_r <= rsq_nxt;
    hit_r <= hit_nxt;
  end

  assign cc_hit = hit_r;

endmodule

// ----- design/cst_rect.sv -----
// ----------------------------------------------------------------------------
// Circle against oriented rectangle test
// Rotates the centre difference, tests the side regions, and squares the
// corner offsets in split partial products before the final compare.
// ----------------------------------------------------------------------------
module cst_rect (
  input  logic               clk,
  input  cst_pkg::cst_geom_t geom,
  output logic               rect_hit
);

  localparam int ROT_W    = cst_pkg::ROT_W;
  localparam int PROD_W   = cst_pkg::PROD_W;
  localparam int SPLIT_W  = cst_pkg::SPLIT_W;
  localparam int PART_W   = cst_pkg::PART_W;
  localparam int SQ_W     = cst_pkg::SQ_W;
  localparam int RSQ_W    = cst_pkg::RSQ_W;
  localparam int FRAC     = cst_pkg::TRIG_FRAC;
  localparam int LIM_DLY  = 3;
  localparam int RSQ_DLY  = 6;
  localparam int FLAG_DLY = 3;

  // Rotation products.
  logic signed [PROD_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [PROD_W-1:0] pxc_nxt, pys_nxt, pxs_nxt, pyc_nxt;
  // Rotated coordinates and their magnitudes.
  logic        [ROT_W-1:0]  rotx_r, roty_r, rotx_nxt, roty_nxt;
  logic        [ROT_W-1:0]  ax_r, ay_r, ax_nxt, ay_nxt;
  // Region test.
  logic        [ROT_W-1:0]  hws, hhs, rss;
  logic                     in_x, in_y, y_bound, x_bound;
  logic        [ROT_W-1:0]  ex_r, ey_r, ex_nxt, ey_nxt;
  logic                     corner_nxt, side_nxt;
  logic                     corner_r [FLAG_DLY];
  logic                     side_r   [FLAG_DLY];
  // Split squares.
  logic        [PART_W-1:0] exhh_r, exhl_r, exll_r, eyhh_r, eyhl_r, eyll_r;
  logic        [PART_W-1:0] exhh_nxt, exhl_nxt, exll_nxt, eyhh_nxt, eyhl_nxt, eyll_nxt;
  logic        [SQ_W-1:0]   ex2_r, ey2_r, ex2_nxt, ey2_nxt;
  logic        [SQ_W:0]     dist2;
  logic        [SQ_W:0]     rad2;
  logic                     hit_r, hit_nxt;
  // Operands carried along.
  cst_pkg::cst_lim_t        lim_nxt;
  cst_pkg::cst_lim_t        lim_r [LIM_DLY];
  logic        [RSQ_W-1:0]  rsq_nxt;
  logic        [RSQ_W-1:0]  rsq_r [RSQ_DLY];

  always_comb begin
    pxc_nxt = $signed(geom.dx) * $signed(geom.cos_a);
    pys_nxt = $signed(geom.dy) * $signed(geom.sin_a);
    pxs_nxt = $signed(geom.dx) * $signed(geom.sin_a);
    pyc_nxt = $signed(geom.dy) * $signed(geom.cos_a);
    rsq_nxt = geom.radius * geom.radius;
    lim_nxt.half_width  = geom.half_width;
    lim_nxt.half_height = geom.half_height;
    lim_nxt.radius      = geom.radius;
  end

  always_comb begin
    rotx_nxt = {pxc_r[PROD_W-1], pxc_r} - {pys_r[PROD_W-1], pys_r};
    roty_nxt = {pxs_r[PROD_W-1], pxs_r} + {pyc_r[PROD_W-1], pyc_r};
  end

  always_comb begin
    ax_nxt = rotx_r[ROT_W-1] ? (ROT_W'(0) - rotx_r) : rotx_r;
    ay_nxt = roty_r[ROT_W-1] ? (ROT_W'(0) - roty_r) : roty_r;
  end

  always_comb begin
    hws        = ROT_W'({lim_r[LIM_DLY-1].half_width, FRAC'(0)});
    hhs        = ROT_W'({lim_r[LIM_DLY-1].half_height, FRAC'(0)});
    rss        = ROT_W'({lim_r[LIM_DLY-1].radius, FRAC'(0)});
    in_x       = ax_r <= hws;
    in_y       = ay_r <= hhs;
    y_bound    = ay_r <= hhs + rss;
    x_bound    = ax_r <= hws + rss;
    ex_nxt     = ax_r - hws;
    ey_nxt     = ay_r - hhs;
    corner_nxt = !in_x && !in_y;
    side_nxt   = in_x ? y_bound : x_bound;
  end

  always_comb begin
    exhh_nxt = ex_r[ROT_W-1:SPLIT_W] * ex_r[ROT_W-1:SPLIT_W];
    exhl_nxt = ex_r[ROT_W-1:SPLIT_W] * ex_r[SPLIT_W-1:0];
    exll_nxt = ex_r[SPLIT_W-1:0] * ex_r[SPLIT_W-1:0];
    eyhh_nxt = ey_r[ROT_W-1:SPLIT_W] * ey_r[ROT_W-1:SPLIT_W];
    eyhl_nxt = ey_r[ROT_W-1:SPLIT_W] * ey_r[SPLIT_W-1:0];
    eyll_nxt = ey_r[SPLIT_W-1:0] * ey_r[SPLIT_W-1:0];
  end

  always_comb begin
    ex2_nxt = (SQ_W'(exhh_r) << (2 * SPLIT_W)) + (SQ_W'(exhl_r) << (SPLIT_W + 1))
            + SQ_W'(exll_r);
    ey2_nxt = (SQ_W'(eyhh_r) << (2 * SPLIT_W)) + (SQ_W'(eyhl_r) << (SPLIT_W + 1))
            + SQ_W'(eyll_r);
  end

  always_comb begin
    dist2   = {1'b0, ex2_r} + {1'b0, ey2_r};
    rad2    = (SQ_W+1)'(rsq_r[RSQ_DLY-1]) << (2 * FRAC);
    hit_nxt = corner_r[FLAG_DLY-1] ? (dist2 <= rad2) : side_r[FLAG_DLY-1];
  end

  always_ff @(posedge clk) begin
    pxc_r    <= pxc_nxt;
    pys_r    <= pys_nxt;
    pxs_r    <= pxs_nxt;
    pyc_r    <= pyc_nxt;
    rotx_r   <= rotx_nxt;
    roty_r   <= roty_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    ex_r     <= ex_nxt;
    ey_r     <= ey_nxt;
    exhh_r   <= exhh_nxt;
    exhl_r   <= exhl_nxt;
    exll_r   <= exll_nxt;
    eyhh_r   <= eyhh_nxt;
    eyhl_r   <= eyhl_nxt;
    eyll_r   <= eyll_nxt;
    ex2_r    <= ex2_nxt;
    ey2_r    <= ey2_nxt;
    hit_r    <= hit_nxt;
    lim_r[0] <= lim_nxt;
    for (int i = 1; i < LIM_DLY; i++) begin
      lim_r[i] <= lim_r[i-1];
    end
    rsq_r[0] <= rsq_nxt;
    for (int i = 1; i < RSQ_DLY; i++) begin
      rsq_r[i] <= rsq_r[i-1];
    end
    corner_r[0] <= corner_nxt;
    side_r[0]   <= side_nxt;
    for (int i = 1; i < FLAG_DLY; i++) begin
      corner_r[i] <= corner_r[i-1];
      side_r[i]   <= side_r[i-1];
    end
  end

  assign rect_hit = hit_r;

endmodule

// ----- design/circle_shape_collision_test.sv -----
// Throughput: one item per clock cycle whenever busy is low; the pipeline never stalls.
// The depth is set by the rectangle path: rotation, region test, split squaring.
// Reset is synchronous and clears all valid bits; busy is high only in reset.
// The receiver cannot stall, so out_valid is a one-cycle strobe per result.
// ----------------------------------------------------------------------------
// Circle shape collision test
// Pipelined overlap test for a circle against a circle or an oriented
// rectangle; a rectangle pair or an unused kind code never collides.
// ----------------------------------------------------------------------------
module circle_shape_collision_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic        [1:0]                  in_func,
  input  logic signed [cst_pkg::COORD_W-1:0] in_circle_x,
  input  logic signed [cst_pkg::COORD_W-1:0] in_circle_y,
  input  logic        [cst_pkg::RAD_W-1:0]   in_circle_radius,
  input  logic signed [cst_pkg::COORD_W-1:0] in_other_x,
  input  logic signed [cst_pkg::COORD_W-1:0] in_other_y,
  input  logic        [cst_pkg::RAD_W-1:0]   in_other_radius,
  input  logic        [cst_pkg::RAD_W-1:0]   in_half_width,
  input  logic        [cst_pkg::RAD_W-1:0]   in_half_height,
  input  logic signed [cst_pkg::TRIG_W-1:0]  in_cos_angle,
  input  logic signed [cst_pkg::TRIG_W-1:0]  in_sin_angle,
  output logic                               out_valid,
  output logic                               out_collision
);

  localparam int CTL_DLY = 8;
  localparam int CC_DLY  = 5;

  cst_pkg::cst_geom_t geom;
  cst_pkg::cst_ctl_t  ctl_nxt;
  cst_pkg::cst_ctl_t  ctl_r [CTL_DLY];
  logic               cc_hit;
  logic               cc_r [CC_DLY];
  logic               rect_hit;
  logic               out_valid_r;
  logic               out_collision_r;
  logic               coll_nxt;

  assign busy = !rst_n;

  cst_front u_front (
    .clk           (clk),
    .circle_x      (in_circle_x),
    .circle_y      (in_circle_y),
    .circle_radius (in_circle_radius),
    .other_x       (in_other_x),
    .other_y       (in_other_y),
    .other_radius  (in_other_radius),
    .half_width    (in_half_width),
    .half_height   (in_half_height),
    .cos_angle     (in_cos_angle),
    .sin_angle     (in_sin_angle),
    .geom          (geom)
  );

  cst_circ u_circ (
    .clk    (clk),
    .geom   (geom),
    .cc_hit (cc_hit)
  );

  cst_rect u_rect (
    .clk      (clk),
    .geom     (geom),
    .rect_hit (rect_hit)
  );

  always_comb begin
    ctl_nxt.valid = start && !busy;
    ctl_nxt.func  = cst_pkg::cst_func_t'(in_func);
  end

  always_comb begin
    case (ctl_r[CTL_DLY-1].func)
      cst_pkg::FUNC_CIRCLE_CIRCLE: coll_nxt = cc_r[CC_DLY-1];
      cst_pkg::FUNC_CIRCLE_RECT:   coll_nxt = rect_hit;
      default:                     coll_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CTL_DLY; i++) begin
        ctl_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i < CTL_DLY; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
      out_valid_r <= ctl_r[CTL_DLY-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    cc_r[0] <= cc_hit;
    for (int i = 1; i < CC_DLY; i++) begin
      cc_r[i] <= cc_r[i-1];
    end
    out_collision_r <= coll_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_collision = out_collision_r;

  // Every result strobe comes from an earlier transfer into the pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 9))
    else $error("result without a matching transfer");

  // Only circle pairs and circle-rectangle pairs can report a collision.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_collision) |->
      ($past(in_func, 9) == cst_pkg::FUNC_CIRCLE_CIRCLE ||
       $past(in_func, 9) == cst_pkg::FUNC_CIRCLE_RECT))
    else $error("collision reported for a pair kind that never collides");

endmodule

// ----- tb/sv/circle_shape_collision_test_checker.sv -----
// ----------------------------------------------------------------------------
// Circle shape collision test checker
// Watches the command and result channels of the collision tester, predicts
// the overlap flag of every accepted shape pair and compares it with the
// result that comes back, in order.
// ----------------------------------------------------------------------------
module circle_shape_collision_test_checker
  import cst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic        [1:0]         in_func,
  input  logic signed [COORD_W-1:0] in_circle_x,
  input  logic signed [COORD_W-1:0] in_circle_y,
  input  logic        [RAD_W-1:0]   in_circle_radius,
  input  logic signed [COORD_W-1:0] in_other_x,
  input  logic signed [COORD_W-1:0] in_other_y,
  input  logic        [RAD_W-1:0]   in_other_radius,
  input  logic        [RAD_W-1:0]   in_half_width,
  input  logic        [RAD_W-1:0]   in_half_height,
  input  logic signed [TRIG_W-1:0]  in_cos_angle,
  input  logic signed [TRIG_W-1:0]  in_sin_angle,
  input  logic                      out_valid,
  input  logic                      out_collision,
  output int                        mismatch_count,
  output int                        pending_count,
  output int                        checked_count,
  output int                        hit_count
);

  typedef struct {
    logic       hit;
    logic [1:0] func;
    int         seq;
  } overlap_rec_t;

  overlap_rec_t expected_overlaps[$];
  overlap_rec_t oldest;
  int           errors = 0;
  int           checked = 0;
  int           hits = 0;
  int           pair_seq = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
    hit_count      = 0;
  end

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic predict_overlap(
    logic [1:0]                func,
    logic signed [COORD_W-1:0] cx,
    logic signed [COORD_W-1:0] cy,
    logic        [RAD_W-1:0]   cr,
    logic signed [COORD_W-1:0] ox,
    logic signed [COORD_W-1:0] oy,
    logic        [RAD_W-1:0]   orad,
    logic        [RAD_W-1:0]   hw,
    logic        [RAD_W-1:0]   hh,
    logic signed [TRIG_W-1:0]  cos_a,
    logic signed [TRIG_W-1:0]  sin_a
  );
    longint       dx;
    longint       dy;
    longint       cl;
    longint       sl;
    longint       rot_x;
    longint       rot_y;
    logic [63:0]  ax;
    logic [63:0]  ay;
    logic [63:0]  half_w;
    logic [63:0]  half_h;
    logic [63:0]  reach;
    logic [63:0]  over_x;
    logic [63:0]  over_y;
    logic [127:0] dist_sq;
    logic [127:0] limit_sq;
    logic         hit;
    dx  = longint'(cx) - longint'(ox);
    dy  = longint'(cy) - longint'(oy);
    cl  = longint'(cos_a);
    sl  = longint'(sin_a);
    hit = 1'b0;
    case (func)
      FUNC_CIRCLE_CIRCLE: begin
        ax       = magnitude(dx);
        ay       = magnitude(dy);
        reach    = 64'(cr) + 64'(orad);
        dist_sq  = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        limit_sq = 128'(reach) * 128'(reach);
        hit      = (dist_sq <= limit_sq);
      end
      FUNC_CIRCLE_RECT: begin
        rot_x  = dx * cl - dy * sl;
        rot_y  = dx * sl + dy * cl;
        ax     = magnitude(rot_x);
        ay     = magnitude(rot_y);
        half_w = 64'(hw) << TRIG_FRAC;
        half_h = 64'(hh) << TRIG_FRAC;
        reach  = 64'(cr) << TRIG_FRAC;
        if (ax <= half_w) begin
          hit = (ay <= half_h + reach);
        end else if (ay <= half_h) begin
          hit = (ax <= half_w + reach);
        end else begin
          over_x   = ax - half_w;
          over_y   = ay - half_h;
          dist_sq  = 128'(over_x) * 128'(over_x) + 128'(over_y) * 128'(over_y);
          limit_sq = 128'(reach) * 128'(reach);
          hit      = (dist_sq <= limit_sq);
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  task automatic note_mismatch(string what);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] collision mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      checked++;
      if (out_collision) begin
        hits++;
      end
      if (expected_overlaps.size() == 0) begin
        note_mismatch($sformatf("result %0b with no pair outstanding", out_collision));
      end else begin
        oldest = expected_overlaps.pop_front();
        if (oldest.hit !== out_collision) begin
          note_mismatch($sformatf("pair %0d func %0d: expected %0b, got %0b",
                                  oldest.seq, oldest.func, oldest.hit, out_collision));
        end
      end
    end
    if (rst_n && start && !busy) begin
      oldest.hit  = predict_overlap(in_func, in_circle_x, in_circle_y, in_circle_radius,
                                    in_other_x, in_other_y, in_other_radius,
                                    in_half_width, in_half_height,
                                    in_cos_angle, in_sin_angle);
      oldest.func = in_func;
      oldest.seq  = pair_seq;
      pair_seq++;
      expected_overlaps.push_back(oldest);
    end
    mismatch_count <= errors;
    pending_count  <= expected_overlaps.size();
    checked_count  <= checked;
    hit_count      <= hits;
  end

endmodule

// ----- tb/sv/circle_shape_collision_test_tb.sv -----
// ----------------------------------------------------------------------------
// Circle shape collision test testbench
// Drives directed corner cases and then random shape pairs into the
// collision tester with varying sender gaps; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module circle_shape_collision_test_tb;
  import cst_pkg::*;

  localparam logic [1:0]         FUNC_UNUSED  = 2'd3;
  localparam int                 RANDOM_PAIRS = 1830;
  localparam int                 CYCLE_LIMIT  = 200000;
  localparam logic signed [31:0] CMIN         = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX         = 32'sh7fff_ffff;
  localparam logic        [30:0] RMAX         = 31'h7fff_ffff;
  localparam logic signed [31:0] ONE          = 32'sh0001_0000;
  localparam logic signed [15:0] TRIG_ONE     = 16'sd16384;

  typedef struct {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [RAD_W-1:0]   cr;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic        [RAD_W-1:0]   orad;
    logic        [RAD_W-1:0]   hw;
    logic        [RAD_W-1:0]   hh;
    logic signed [TRIG_W-1:0]  cos_a;
    logic signed [TRIG_W-1:0]  sin_a;
  } shape_pair_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic        [1:0]         in_func = '0;
  logic signed [COORD_W-1:0] in_circle_x = '0;
  logic signed [COORD_W-1:0] in_circle_y = '0;
  logic        [RAD_W-1:0]   in_circle_radius = '0;
  logic signed [COORD_W-1:0] in_other_x = '0;
  logic signed [COORD_W-1:0] in_other_y = '0;
  logic        [RAD_W-1:0]   in_other_radius = '0;
  logic        [RAD_W-1:0]   in_half_width = '0;
  logic        [RAD_W-1:0]   in_half_height = '0;
  logic signed [TRIG_W-1:0]  in_cos_angle = '0;
  logic signed [TRIG_W-1:0]  in_sin_angle = '0;
  logic                      out_valid;
  logic                      out_collision;
  int                        mismatch_count;
  int                        pending_count;
  int                        checked_count;
  int                        hit_count;
  int                        cycle_count = 0;
  int                        directed_pairs = 0;
  int                        idle_pct = 0;

  circle_shape_collision_test uut (.*);

  circle_shape_collision_test_checker checker_i (.*);

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic shape_pair_t make_pair(
    logic [1:0]                func,
    logic signed [COORD_W-1:0] cx,
    logic signed [COORD_W-1:0] cy,
    logic        [RAD_W-1:0]   cr,
    logic signed [COORD_W-1:0] ox,
    logic signed [COORD_W-1:0] oy,
    logic        [RAD_W-1:0]   orad,
    logic        [RAD_W-1:0]   hw,
    logic        [RAD_W-1:0]   hh,
    logic signed [TRIG_W-1:0]  cos_a,
    logic signed [TRIG_W-1:0]  sin_a
  );
    shape_pair_t p;
    p.func  = func;
    p.cx    = cx;
    p.cy    = cy;
    p.cr    = cr;
    p.ox    = ox;
    p.oy    = oy;
    p.orad  = orad;
    p.hw    = hw;
    p.hh    = hh;
    p.cos_a = cos_a;
    p.sin_a = sin_a;
    return p;
  endfunction

  function automatic logic [30:0] near_size();
    return 31'($urandom_range(0, 32'h0010_0000));
  endfunction

  function automatic logic signed [31:0] near_offset();
    return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      p.func = FUNC_CIRCLE_CIRCLE;
    end else if (pick < 80) begin
      p.func = FUNC_CIRCLE_RECT;
    end else if (pick < 90) begin
      p.func = FUNC_RECT_RECT;
    end else begin
      p.func = FUNC_UNUSED;
    end
    if ($urandom_range(0, 99) < 65) begin
      p.ox    = $urandom;
      p.oy    = $urandom;
      p.cx    = p.ox + near_offset();
      p.cy    = p.oy + near_offset();
      p.cr    = near_size();
      p.orad  = near_size();
      p.hw    = near_size();
      p.hh    = near_size();
      p.cos_a = 16'(int'($urandom_range(0, 32768)) - 16384);
      p.sin_a = 16'(int'($urandom_range(0, 32768)) - 16384);
    end else begin
      p.cx    = $urandom;
      p.cy    = $urandom;
      p.cr    = 31'($urandom);
      p.ox    = $urandom;
      p.oy    = $urandom;
      p.orad  = 31'($urandom);
      p.hw    = 31'($urandom);
      p.hh    = 31'($urandom);
      p.cos_a = 16'($urandom);
      p.sin_a = 16'($urandom);
    end
    return p;
  endfunction

  task automatic drive_pair(shape_pair_t p);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_func          <= p.func;
    in_circle_x      <= p.cx;
    in_circle_y      <= p.cy;
    in_circle_radius <= p.cr;
    in_other_x       <= p.ox;
    in_other_y       <= p.oy;
    in_other_radius  <= p.orad;
    in_half_width    <= p.hw;
    in_half_height   <= p.hh;
    in_cos_angle     <= p.cos_a;
    in_sin_angle     <= p.sin_a;
    start            <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  task automatic run_directed();
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, CMIN, CMIN, RMAX, CMAX, CMAX, RMAX,
                         0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, CMAX, 0, RMAX, CMIN, 0, RMAX, 0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, CMAX, 5, RMAX, CMIN + 1, 5, RMAX,
                         0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, 0, 0, 31'(2 * ONE), 3 * ONE, 4 * ONE,
                         31'(3 * ONE), 0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, 0, 0, 31'(2 * ONE), 3 * ONE, 4 * ONE,
                         31'(3 * ONE - 1), 0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 10 * ONE, 0, 31'(2 * ONE), 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 10 * ONE, 0, 31'(2 * ONE - 1), 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 11 * ONE, 8 * ONE, 31'(5 * ONE), 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 11 * ONE, 8 * ONE, 31'(5 * ONE - 1), 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, ONE, ONE, 0, 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 0, 10 * ONE, 31'(2 * ONE), 0, 0, 0,
                         31'(8 * ONE), 31'(4 * ONE), 0, TRIG_ONE));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, CMAX, CMIN, RMAX, CMIN, CMAX, 0,
                         RMAX, RMAX, 16'sh8000, 16'sh7fff));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, CMAX, CMAX, 0, CMIN, CMIN, 0, 0, 0, 0, 0));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, 3 * ONE, -7 * ONE, 31'(ONE), -2 * ONE, ONE, 0,
                         31'(2 * ONE), 31'(3 * ONE), -TRIG_ONE, -TRIG_ONE));
    drive_pair(make_pair(FUNC_CIRCLE_RECT, CMIN, CMIN, 0, CMAX, CMAX, 0,
                         RMAX, RMAX, 16'sh7fff, 16'sh8000));
    drive_pair(make_pair(FUNC_RECT_RECT, 0, 0, RMAX, 0, 0, RMAX, RMAX, RMAX,
                         TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_UNUSED, 0, 0, RMAX, 0, 0, RMAX, RMAX, RMAX, TRIG_ONE, 0));
    drive_pair(make_pair(FUNC_CIRCLE_CIRCLE, -1, -1, RMAX, -1, -1, RMAX, RMAX, RMAX,
                         -1, -1));
    drive_pair(make_pair(FUNC_UNUSED, -1, -1, RMAX, -1, -1, RMAX, RMAX, RMAX, -1, -1));
    directed_pairs = 20;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy);

    run_directed();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i < RANDOM_PAIRS / 3) begin
        idle_pct = 19;
      end else if (i < 2 * RANDOM_PAIRS / 3) begin
        idle_pct = 57;
      end else begin
        idle_pct = 0;
      end
      drive_pair(random_pair());
    end
    start <= 1'b0;

    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d shape pairs (%0d directed), %0d results checked, %0d overlaps.",
             directed_pairs + RANDOM_PAIRS, directed_pairs, checked_count, hit_count);
    $display("Random pairs ran with sender gaps of 19%%, then 57%%, then none.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
